### rtl/touch_gesture_filter_unit_assert.svh
// Assertion macros for the touch gesture filter checker.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef TOUCH_GESTURE_FILTER_UNIT_ASSERT_SVH
`define TOUCH_GESTURE_FILTER_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define TGF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition in one cycle that forces another condition in the next cycle.
`define TGF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

### rtl/tgf_pkg.sv
// Shared types and constants of the touch gesture filter.
// No dependencies; the interfaces, modules and checker of the block use this package.
package tgf_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;

	localparam int COORD_W = 12;
	localparam int DELTA_W = 13;
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Depth of the queue between front and back.
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_JITTER      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRAG        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_MAX     = 3'd6;

	// Orientation bits.
	localparam int ORI_SWAP     = 0;
	localparam int ORI_MIRROR_X = 1;
	localparam int ORI_MIRROR_Y = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [2:0]         orientation;
		logic [CNT_W-1:0]   press_frames;
		logic [CNT_W-1:0]   release_frames;
		logic [COORD_W-1:0] jitter_px;
		logic [COORD_W-1:0] jump_reject_px;
		logic [COORD_W-1:0] drag_threshold_px;
		logic [15:0]        tap_max_ms;
	} cfg_t;

	// A classified sample as it travels from front to back.
	typedef struct packed {
		logic               pressed;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TIME_W-1:0]  now_ms;
	} q_item_t;

endpackage

### rtl/tgf_ifs.sv
// Channel interfaces of the touch gesture filter: samples, results, configuration.
// Depends on tgf_pkg for field widths.
interface tgf_sample_if;
	logic                        valid;
	logic                        ready;
	logic                        touched;
	logic [tgf_pkg::COORD_W-1:0] raw_x;
	logic [tgf_pkg::COORD_W-1:0] raw_y;
	logic [tgf_pkg::TIME_W-1:0]  now_ms;

	modport source (output valid, touched, raw_x, raw_y, now_ms, input ready);
	modport sink (input valid, touched, raw_x, raw_y, now_ms, output ready);
endinterface

interface tgf_result_if;
	logic                        valid;
	logic                        ready;
	logic                        tap_event;
	logic [tgf_pkg::COORD_W-1:0] tap_x;
	logic [tgf_pkg::COORD_W-1:0] tap_y;
	logic                        drag_event;
	logic signed [tgf_pkg::DELTA_W-1:0] drag_dx;
	logic signed [tgf_pkg::DELTA_W-1:0] drag_dy;
	logic                        contact_active;
	logic [tgf_pkg::COORD_W-1:0] current_x;
	logic [tgf_pkg::COORD_W-1:0] current_y;

	modport source (output valid, tap_event, tap_x, tap_y, drag_event, drag_dx, drag_dy,
		contact_active, current_x, current_y, input ready);
	modport sink (input valid, tap_event, tap_x, tap_y, drag_event, drag_dx, drag_dy,
		contact_active, current_x, current_y, output ready);
endinterface

interface tgf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tgf_pkg::CFG_IDX_W-1:0]  index;
	logic [tgf_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/tgf_front.sv
// Front end: accepts samples, applies orientation and marks off-screen points as not pressed.
// Depends on tgf_pkg and tgf_sample_if.
module tgf_front (
	tgf_sample_if.sink          sample,
	input  logic [2:0]          orientation,
	input  logic                q_full,
	output logic                push,
	output tgf_pkg::q_item_t    item
);
	import tgf_pkg::*;

	localparam logic signed [13:0] SW = 14'(SCREEN_WIDTH);
	localparam logic signed [13:0] SH = 14'(SCREEN_HEIGHT);

	logic signed [13:0] rx;
	logic signed [13:0] ry;
	logic               on_screen;

	// A request is taken whenever the queue has room.
	assign sample.ready = !q_full;
	assign push = sample.valid && !q_full;

	// Swap, then mirror, in a range wide enough to see negative results.
	always_comb begin
		if (orientation[ORI_SWAP]) begin
			rx = $signed({2'b00, sample.raw_y});
			ry = $signed({2'b00, sample.raw_x});
		end else begin
			rx = $signed({2'b00, sample.raw_x});
			ry = $signed({2'b00, sample.raw_y});
		end
		if (orientation[ORI_MIRROR_X]) begin
			rx = SW - 14'sd1 - rx;
		end
		if (orientation[ORI_MIRROR_Y]) begin
			ry = SH - 14'sd1 - ry;
		end
		on_screen = !rx[13] && (rx < SW) && !ry[13] && (ry < SH);
	end

	assign item.pressed = sample.touched && on_screen;
	assign item.x       = rx[COORD_W-1:0];
	assign item.y       = ry[COORD_W-1:0];
	assign item.now_ms  = sample.now_ms;

endmodule

### rtl/tgf_queue.sv
// Short queue between the front end and the gesture back end.
// Depends on tgf_pkg for the item type and depth.
module tgf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tgf_pkg::q_item_t push_item,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output tgf_pkg::q_item_t head
);
	import tgf_pkg::*;

	q_item_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Storage needs no reset; entries are read only after they are written.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers wrap at the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/tgf_back.sv
// Back end: debounce, start and motion tracking, drag and tap decisions.
// Depends on tgf_pkg and tgf_result_if; drives the registered result channel.
module tgf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tgf_pkg::cfg_t    cfg,
	input  logic             q_valid,
	input  tgf_pkg::q_item_t q_head,
	output logic             pop,
	tgf_result_if.source     result
);
	import tgf_pkg::*;

	// Gesture state.
	logic [CNT_W-1:0]   press_cnt_q, release_cnt_q;
	logic               active_q, drag_seen_q;
	logic [COORD_W-1:0] start_x_q, start_y_q, last_x_q, last_y_q, pos_x_q, pos_y_q;
	logic [TIME_W-1:0]  start_time_q;
	logic [COORD_W-1:0] tap_x_q, tap_y_q;

	// Result register.
	logic                      out_valid_q;
	logic                      tap_ev_q, drag_ev_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;

	// Next-state values.
	logic [CNT_W-1:0]   press_cnt_n, release_cnt_n;
	logic               active_n, drag_seen_n;
	logic [COORD_W-1:0] start_x_n, start_y_n, last_x_n, last_y_n, pos_x_n, pos_y_n;
	logic [TIME_W-1:0]  start_time_n;
	logic [COORD_W-1:0] tap_x_n, tap_y_n;
	logic               tap_ev_n, drag_ev_n;
	logic signed [DELTA_W-1:0] dx_n, dy_n;

	logic [COORD_W-1:0] mx, my;
	logic               stable_pressed, stable_released;
	logic signed [DELTA_W-1:0] dx_raw, dy_raw, sx_raw, sy_raw, fdx, fdy;
	logic [COORD_W-1:0] mag_dx, mag_dy, mag_sx, mag_sy, total;
	logic [TIME_W-1:0]  duration;

	// One sample moves on whenever the result register is free or being drained.
	assign pop = q_valid && (!out_valid_q || result.ready);

	always_comb begin
		// A sample without a valid point keeps the current position.
		mx = q_head.pressed ? q_head.x : pos_x_q;
		my = q_head.pressed ? q_head.y : pos_y_q;

		// Saturating debounce counters.
		if (q_head.pressed) begin
			press_cnt_n   = (press_cnt_q == CNT_MAX) ? press_cnt_q : press_cnt_q + 1'b1;
			release_cnt_n = '0;
		end else begin
			release_cnt_n = (release_cnt_q == CNT_MAX) ? release_cnt_q : release_cnt_q + 1'b1;
			press_cnt_n   = '0;
		end
		stable_pressed  = press_cnt_n >= cfg.press_frames;
		stable_released = release_cnt_n >= cfg.release_frames;

		// Deltas from the last point and from the start point.
		dx_raw = $signed({1'b0, mx}) - $signed({1'b0, last_x_q});
		dy_raw = $signed({1'b0, my}) - $signed({1'b0, last_y_q});
		sx_raw = $signed({1'b0, mx}) - $signed({1'b0, start_x_q});
		sy_raw = $signed({1'b0, my}) - $signed({1'b0, start_y_q});
		mag_dx = dx_raw[DELTA_W-1] ? COORD_W'(-dx_raw) : dx_raw[COORD_W-1:0];
		mag_dy = dy_raw[DELTA_W-1] ? COORD_W'(-dy_raw) : dy_raw[COORD_W-1:0];
		mag_sx = sx_raw[DELTA_W-1] ? COORD_W'(-sx_raw) : sx_raw[COORD_W-1:0];
		mag_sy = sy_raw[DELTA_W-1] ? COORD_W'(-sy_raw) : sy_raw[COORD_W-1:0];
		total  = (mag_sx > mag_sy) ? mag_sx : mag_sy;
		fdx    = (mag_dx <= cfg.jitter_px) ? '0 : dx_raw;
		fdy    = (mag_dy <= cfg.jitter_px) ? '0 : dy_raw;
		duration = q_head.now_ms - start_time_q;

		active_n     = active_q;
		drag_seen_n  = drag_seen_q;
		start_x_n    = start_x_q;
		start_y_n    = start_y_q;
		last_x_n     = last_x_q;
		last_y_n     = last_y_q;
		pos_x_n      = pos_x_q;
		pos_y_n      = pos_y_q;
		start_time_n = start_time_q;
		tap_x_n      = tap_x_q;
		tap_y_n      = tap_y_q;
		tap_ev_n     = 1'b0;
		drag_ev_n    = 1'b0;
		dx_n         = '0;
		dy_n         = '0;

		if (stable_pressed && !active_q) begin
			// Contact starts here.
			active_n     = 1'b1;
			start_x_n    = mx;
			start_y_n    = my;
			last_x_n     = mx;
			last_y_n     = my;
			pos_x_n      = mx;
			pos_y_n      = my;
			start_time_n = q_head.now_ms;
			drag_seen_n  = 1'b0;
		end else if (stable_pressed) begin
			// Contact held: track, and evaluate drag only for steps without a glitch jump.
			pos_x_n  = mx;
			pos_y_n  = my;
			last_x_n = mx;
			last_y_n = my;
			if (mag_dx <= cfg.jump_reject_px && mag_dy <= cfg.jump_reject_px) begin
				if (total > cfg.drag_threshold_px) begin
					drag_seen_n = 1'b1;
					if (fdx != '0 || fdy != '0) begin
						drag_ev_n = 1'b1;
						dx_n      = fdx;
						dy_n      = fdy;
					end
				end
			end
		end else if (stable_released && active_q) begin
			// Release: a short press without a drag is a tap at the start point.
			active_n = 1'b0;
			if (!drag_seen_q && duration < {16'b0, cfg.tap_max_ms}) begin
				tap_ev_n = 1'b1;
				tap_x_n  = start_x_q;
				tap_y_n  = start_y_q;
			end
		end
	end

	// State and result register update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_cnt_q   <= '0;
			release_cnt_q <= '0;
			active_q      <= 1'b0;
			drag_seen_q   <= 1'b0;
			start_x_q     <= '0;
			start_y_q     <= '0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			pos_x_q       <= '0;
			pos_y_q       <= '0;
			start_time_q  <= '0;
			tap_x_q       <= '0;
			tap_y_q       <= '0;
			out_valid_q   <= 1'b0;
			tap_ev_q      <= 1'b0;
			drag_ev_q     <= 1'b0;
			dx_q          <= '0;
			dy_q          <= '0;
		end else begin
			if (pop) begin
				press_cnt_q   <= press_cnt_n;
				release_cnt_q <= release_cnt_n;
				active_q      <= active_n;
				drag_seen_q   <= drag_seen_n;
				start_x_q     <= start_x_n;
				start_y_q     <= start_y_n;
				last_x_q      <= last_x_n;
				last_y_q      <= last_y_n;
				pos_x_q       <= pos_x_n;
				pos_y_q       <= pos_y_n;
				start_time_q  <= start_time_n;
				tap_x_q       <= tap_x_n;
				tap_y_q       <= tap_y_n;
				tap_ev_q      <= tap_ev_n;
				drag_ev_q     <= drag_ev_n;
				dx_q          <= dx_n;
				dy_q          <= dy_n;
				out_valid_q   <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The held state after an update is exactly what the result reports.
	assign result.valid          = out_valid_q;
	assign result.tap_event      = tap_ev_q;
	assign result.tap_x          = tap_x_q;
	assign result.tap_y          = tap_y_q;
	assign result.drag_event     = drag_ev_q;
	assign result.drag_dx        = dx_q;
	assign result.drag_dy        = dy_q;
	assign result.contact_active = active_q;
	assign result.current_x      = pos_x_q;
	assign result.current_y      = pos_y_q;

endmodule

### rtl/touch_gesture_filter_unit.sv
// Top level of the touch gesture filter: configuration registers and channel wiring.
// Depends on tgf_pkg, tgf_ifs, tgf_front, tgf_queue and tgf_back.
//
//  Channel   Direction  Moves
//  sample    in         touched, raw_x, raw_y, now_ms (one touch sample)
//  result    out        tap, drag, contact and position report (one per sample)
//  cfg       in         index, data (register write, always ready)
//
// One sample per clock is sustained while results are taken as soon as they are offered.
// A taken sample is first written into the queue, then moves into the result register, where
// its result is offered until it is taken.
// The two-entry queue lets the front keep taking samples while a result waits to be taken.
// Reset (arst_n low) clears all gesture state and loads the register defaults at once.
module touch_gesture_filter_unit (
	input  logic          clk,
	input  logic          arst_n,
	tgf_sample_if.sink    sample,
	tgf_result_if.source  result,
	tgf_cfg_if.sink       cfg
);
	import tgf_pkg::*;

	cfg_t    cfg_q;
	logic    q_full, q_push, q_pop, q_valid;
	q_item_t front_item, q_head;

	// Register writes are taken at any time; the index past the list is ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation       <= 3'd0;
			cfg_q.press_frames      <= 8'd2;
			cfg_q.release_frames    <= 8'd2;
			cfg_q.jitter_px         <= 12'd3;
			cfg_q.jump_reject_px    <= 12'd45;
			cfg_q.drag_threshold_px <= 12'd10;
			cfg_q.tap_max_ms        <= 16'd300;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ORIENTATION: cfg_q.orientation       <= cfg.data[2:0];
				REG_PRESS:       cfg_q.press_frames      <= cfg.data[CNT_W-1:0];
				REG_RELEASE:     cfg_q.release_frames    <= cfg.data[CNT_W-1:0];
				REG_JITTER:      cfg_q.jitter_px         <= cfg.data[COORD_W-1:0];
				REG_JUMP:        cfg_q.jump_reject_px    <= cfg.data[COORD_W-1:0];
				REG_DRAG:        cfg_q.drag_threshold_px <= cfg.data[COORD_W-1:0];
				REG_TAP_MAX:     cfg_q.tap_max_ms        <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Front end classifies samples into the queue.
	tgf_front u_front (
		.sample      (sample),
		.orientation (cfg_q.orientation),
		.q_full      (q_full),
		.push        (q_push),
		.item        (front_item)
	);

	tgf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	// Back end updates gesture state and drives the result channel.
	tgf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (q_pop),
		.result  (result)
	);

endmodule

### rtl/tgf_checker.sv
// Port-level checker of the touch gesture filter, bound to the top level.
// Depends on touch_gesture_filter_unit_assert.svh and tgf_pkg.
`include "touch_gesture_filter_unit_assert.svh"

module tgf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               r_valid,
	input logic                               r_ready,
	input logic                               tap_event,
	input logic                               drag_event,
	input logic signed [tgf_pkg::DELTA_W-1:0] drag_dx,
	input logic signed [tgf_pkg::DELTA_W-1:0] drag_dy,
	input logic                               contact_active
);
	import tgf_pkg::*;

	// A pending result stays offered until it is taken.
	`TGF_ASSERT_NEXT(a_result_held, r_valid && !r_ready, r_valid, "result dropped while stalled")

	// A drag is only reported while contact is held, and with a nonzero delta.
	`TGF_ASSERT(a_drag_in_contact, r_valid && drag_event |-> contact_active && (drag_dx != '0 || drag_dy != '0), "drag without contact or movement")

	// A tap ends the contact.
	`TGF_ASSERT(a_tap_releases, r_valid && tap_event |-> !contact_active && !drag_event, "tap while contact held")

	// Without a drag the deltas read zero.
	`TGF_ASSERT(a_idle_delta_zero, r_valid && !drag_event |-> drag_dx == '0 && drag_dy == '0, "nonzero delta without drag")

endmodule

bind touch_gesture_filter_unit tgf_checker u_tgf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.r_valid        (result.valid),
	.r_ready        (result.ready),
	.tap_event      (result.tap_event),
	.drag_event     (result.drag_event),
	.drag_dx        (result.drag_dx),
	.drag_dy        (result.drag_dy),
	.contact_active (result.contact_active)
);
